FILE: hdl/mtb_pkg.sv
`timescale 1ns / 1ps

package mtb_pkg;

  // Item field widths
  localparam int OP_W    = 2;
  localparam int CH_W    = 3;
  localparam int LOAD_W  = 16;
  localparam int TAG_W   = 8;
  localparam int TICK_W  = 32;
  localparam int IN_DW   = 32;
  localparam int OUT_DW  = 48;

  // Operation codes
  localparam logic [OP_W-1:0] OP_TICK    = 2'd0;
  localparam logic [OP_W-1:0] OP_ARM     = 2'd1;
  localparam logic [OP_W-1:0] OP_DEARM   = 2'd2;
  localparam logic [OP_W-1:0] OP_SERVICE = 2'd3;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic exec;   // input transaction accepted, execute its op
    logic step;   // advance the service scan by one channel
    logic emit;   // current scan channel is delivered this cycle
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic svc_scan;     // input is a service op with something pending
    logic pend_cur;     // scan channel is armed and expired
    logic pend_higher;  // some later channel is pending
    logic out_free;     // output register can take a result this cycle
  } dp_status_t;

endpackage

FILE: hdl/mtb_ctrl.sv
`timescale 1ns / 1ps

module mtb_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  mtb_pkg::dp_status_t   status,
  output mtb_pkg::ctl_cmd_t     cmd
);
  import mtb_pkg::*;

  state_t state;
  state_t state_next;

  // Input is taken only between service scans with room in the output register
  assign in_ready = (state == S_IDLE) && status.out_free;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        cmd.exec = in_valid && in_ready;
        if (cmd.exec && status.svc_scan) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        // skip idle channels, wait on a stalled output for pending ones
        cmd.step = !status.pend_cur || status.out_free;
        cmd.emit = cmd.step && status.pend_cur;
        if (cmd.emit && !status.pend_higher) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: hdl/mtb_datapath.sv
`timescale 1ns / 1ps

module mtb_datapath #(
  parameter int CHANNELS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [mtb_pkg::OP_W-1:0]      op,
  input  logic [mtb_pkg::CH_W-1:0]      channel,
  input  logic [mtb_pkg::LOAD_W-1:0]    load_value,
  input  logic [mtb_pkg::TAG_W-1:0]     tag_in,
  input  mtb_pkg::ctl_cmd_t             cmd,
  output mtb_pkg::dp_status_t           status,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mtb_pkg::TICK_W-1:0]    tick_count,
  output logic                          tick_expired,
  output logic                          delivered,
  output logic [mtb_pkg::CH_W-1:0]      expired_channel,
  output logic [mtb_pkg::TAG_W-1:0]     tag_out,
  output logic                          last
);
  import mtb_pkg::*;

  // Only channels addressable by the channel field can ever be armed
  localparam int CH_REACH = 2 ** CH_W;
  localparam int SCAN_N   = (CHANNELS < CH_REACH) ? CHANNELS : CH_REACH;

  logic [LOAD_W-1:0] remaining [CHANNELS];
  logic [TAG_W-1:0]  chan_tag  [CHANNELS];
  logic [CHANNELS-1:0] armed;
  logic [CHANNELS-1:0] expired;
  logic [TICK_W-1:0]   tick_counter;
  logic [CH_W-1:0]     scan_idx;

  logic [CHANNELS-1:0] lane_active;
  logic [CHANNELS-1:0] lane_expire;
  logic [LOAD_W-1:0]   lane_dec [CHANNELS];
  logic [CHANNELS-1:0] lane_sel;
  logic [SCAN_N-1:0]   pend_vec;
  logic [TAG_W-1:0]    tag_cur;
  logic                tick_any;
  logic                is_tick;
  logic                load_simple;

  assign is_tick = (op == OP_TICK);

  // Per-channel countdown lanes and arm/dearm decode
  always_comb begin
    tick_any = 1'b0;
    for (int i = 0; i < CHANNELS; i++) begin
      lane_active[i] = armed[i] && !expired[i];
      lane_dec[i]    = (remaining[i] != '0) ? remaining[i] - 1'b1 : '0;
      lane_expire[i] = lane_active[i] && (lane_dec[i] == '0);
      tick_any       = tick_any | lane_expire[i];
      // lanes beyond the channel field's reach are never selected
      lane_sel[i]    = (i < CH_REACH) && (channel == CH_W'(i));
    end
  end

  // Service scan status
  always_comb begin
    status.pend_cur    = 1'b0;
    status.pend_higher = 1'b0;
    tag_cur            = '0;
    for (int i = 0; i < SCAN_N; i++) begin
      pend_vec[i] = armed[i] && expired[i];
      if (scan_idx == CH_W'(i)) begin
        status.pend_cur = pend_vec[i];
        tag_cur         = chan_tag[i];
      end
      if (CH_W'(i) > scan_idx) begin
        status.pend_higher = status.pend_higher | pend_vec[i];
      end
    end
  end

  assign status.svc_scan = (op == OP_SERVICE) && (pend_vec != '0);
  assign status.out_free = !out_valid || out_ready;

  // Ops other than a non-empty service answer at once with a single result
  assign load_simple = cmd.exec && !status.svc_scan;

  // Channel state
  always_ff @(posedge clk) begin
    if (rst) begin
      armed        <= '0;
      expired      <= '0;
      tick_counter <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        remaining[i] <= '0;
        chan_tag[i]  <= '0;
      end
    end else if (cmd.exec) begin
      if (is_tick) begin
        tick_counter <= tick_counter + 1'b1;
      end
      for (int i = 0; i < CHANNELS; i++) begin
        if (is_tick) begin
          if (lane_active[i]) begin
            remaining[i] <= lane_dec[i];
            if (lane_expire[i]) begin
              expired[i] <= 1'b1;
            end
          end
        end else if (op == OP_ARM && lane_sel[i]) begin
          remaining[i] <= load_value;
          chan_tag[i]  <= tag_in;
          expired[i]   <= 1'b0;
          armed[i]     <= 1'b1;
        end else if (op == OP_DEARM && lane_sel[i]) begin
          armed[i] <= 1'b0;
        end
      end
    end else if (cmd.emit) begin
      for (int i = 0; i < SCAN_N; i++) begin
        if (scan_idx == CH_W'(i)) begin
          armed[i]   <= 1'b0;
          expired[i] <= 1'b0;
        end
      end
    end
  end

  // Scan index
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
    end else if (cmd.exec) begin
      scan_idx <= '0;
    end else if (cmd.step) begin
      scan_idx <= scan_idx + 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_simple || cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_simple) begin
      tick_count      <= is_tick ? tick_counter + 1'b1 : tick_counter;
      tick_expired    <= is_tick && tick_any;
      delivered       <= 1'b0;
      expired_channel <= '0;
      tag_out         <= '0;
      last            <= 1'b1;
    end else if (cmd.emit) begin
      tick_count      <= tick_counter;
      tick_expired    <= 1'b0;
      delivered       <= 1'b1;
      expired_channel <= scan_idx;
      tag_out         <= tag_cur;
      last            <= !status.pend_higher;
    end
  end

endmodule

FILE: hdl/multi_channel_oneshot_timer_bank_top.sv
// Tick, arm, dearm, empty service: one result, the cycle after the input transaction.
// Non-empty service: the scan walks the channels one per cycle (up to 8), waiting at a
// pending one on a stalled output, delivering each pending channel; next input accepted
// once the last result is registered. Throughput: one item per cycle for tick/arm/dearm
// while the result side keeps up; output stalls hold the input off.
// Synchronous active-high reset clears all channels, the tick counter and the output.
`timescale 1ns / 1ps

module multi_channel_oneshot_timer_bank_top #(
  parameter int CHANNELS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [1:0] op, [4:2] channel, [20:5] load_value, [28:21] tag_in, [31:29] zero
  input  logic [31:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [31:0] tick_count, [32] tick_expired, [33] delivered,
  // [36:34] expired_channel, [44:37] tag_out, [47:45] zero
  output logic [47:0] m_axis_tdata,
  output logic        m_axis_tlast
);
  import mtb_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t status;

  logic [TICK_W-1:0] tick_count;
  logic              tick_expired;
  logic              delivered;
  logic [CH_W-1:0]   expired_channel;
  logic [TAG_W-1:0]  tag_out;

  mtb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  mtb_datapath #(
    .CHANNELS (CHANNELS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .op              (s_axis_tdata[1:0]),
    .channel         (s_axis_tdata[4:2]),
    .load_value      (s_axis_tdata[20:5]),
    .tag_in          (s_axis_tdata[28:21]),
    .cmd             (cmd),
    .status          (status),
    .out_valid       (m_axis_tvalid),
    .out_ready       (m_axis_tready),
    .tick_count      (tick_count),
    .tick_expired    (tick_expired),
    .delivered       (delivered),
    .expired_channel (expired_channel),
    .tag_out         (tag_out),
    .last            (m_axis_tlast)
  );

  assign m_axis_tdata = {3'b000, tag_out, expired_channel, delivered, tick_expired,
                         tick_count};

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import mtb_pkg::*;

  localparam int CHANNELS = 8;
  localparam int DIR_ROWS = 25;
  localparam int RANDOM_ITEMS = 305;

  // One result transaction as seen on the master side
  typedef struct packed {
    logic [TICK_W-1:0] tick_count;
    logic              tick_expired;
    logic              delivered;
    logic [CH_W-1:0]   channel;
    logic [TAG_W-1:0]  tag;
    logic              fin;
  } timer_result_t;

  // One stimulus row; typed rows carry their single expected result inline
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [CH_W-1:0]   ch;
    logic [LOAD_W-1:0] load;
    logic [TAG_W-1:0]  tag;
    logic              typed;
    logic [TICK_W-1:0] tc;
    logic              any;
  } cmd_row_t;

  // Directed part: empty service, extremes, zero length, zero tag, rearm,
  // dearm of an expired channel, several expirations in one service
  localparam cmd_row_t DIRECTED [DIR_ROWS] = '{
    '{OP_SERVICE, 3'd0, 16'h0000, 8'h00, 1'b1, 32'd0, 1'b0},
    '{OP_TICK,    3'd0, 16'h0000, 8'h00, 1'b1, 32'd1, 1'b0},
    '{OP_ARM,     3'd0, 16'h0000, 8'h00, 1'b1, 32'd1, 1'b0},
    '{OP_ARM,     3'd7, 16'hffff, 8'hff, 1'b1, 32'd1, 1'b0},
    '{OP_ARM,     3'd1, 16'h0001, 8'ha5, 1'b0, 32'd0, 1'b0},
    '{OP_ARM,     3'd2, 16'h0002, 8'h5a, 1'b0, 32'd0, 1'b0},
    '{OP_TICK,    3'd0, 16'h0000, 8'h00, 1'b1, 32'd2, 1'b1},
    '{OP_SERVICE, 3'd0, 16'h0000, 8'h00, 1'b0, 32'd0, 1'b0},
    '{OP_ARM,     3'd3, 16'h0003, 8'h3c, 1'b0, 32'd0, 1'b0},
    '{OP_TICK,    3'd0, 16'h0000, 8'h00, 1'b0, 32'd0, 1'b0},
    '{OP_DEARM,   3'd2, 16'h0000, 8'h00, 1'b0, 32'd0, 1'b0},
    '{OP_TICK,    3'd5, 16'hffff, 8'hff, 1'b0, 32'd0, 1'b0},
    '{OP_SERVICE, 3'd7, 16'hffff, 8'hff, 1'b0, 32'd0, 1'b0},
    '{OP_ARM,     3'd2, 16'h0001, 8'h11, 1'b0, 32'd0, 1'b0},
    '{OP_ARM,     3'd3, 16'h0005, 8'hc3, 1'b0, 32'd0, 1'b0},
    '{OP_ARM,     3'd4, 16'h0001, 8'h44, 1'b0, 32'd0, 1'b0},
    '{OP_ARM,     3'd5, 16'h0001, 8'h55, 1'b0, 32'd0, 1'b0},
    '{OP_ARM,     3'd6, 16'h0001, 8'h66, 1'b0, 32'd0, 1'b0},
    '{OP_TICK,    3'd0, 16'h0000, 8'h00, 1'b0, 32'd0, 1'b0},
    '{OP_TICK,    3'd0, 16'h0000, 8'h00, 1'b0, 32'd0, 1'b0},
    '{OP_SERVICE, 3'd0, 16'h0000, 8'h00, 1'b0, 32'd0, 1'b0},
    '{OP_DEARM,   3'd7, 16'h0000, 8'h00, 1'b0, 32'd0, 1'b0},
    '{OP_DEARM,   3'd0, 16'h0000, 8'h00, 1'b0, 32'd0, 1'b0},
    '{OP_SERVICE, 3'd0, 16'h0000, 8'h00, 1'b0, 32'd0, 1'b0},
    '{OP_ARM,     3'd5, 16'h5a5a, 8'hc3, 1'b0, 32'd0, 1'b0}
  };

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  // [1:0] op, [4:2] channel, [20:5] load_value, [28:21] tag_in, [31:29] zero
  logic [IN_DW-1:0]  s_axis_tdata = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  // [31:0] tick_count, [32] tick_expired, [33] delivered,
  // [36:34] expired_channel, [44:37] tag_out, [47:45] zero
  logic [OUT_DW-1:0] m_axis_tdata;
  logic              m_axis_tlast;

  // Shadow of the timer bank
  logic [LOAD_W-1:0] count_left [CHANNELS];
  logic              is_armed   [CHANNELS];
  logic              is_expired [CHANNELS];
  logic [TAG_W-1:0]  cb_tag     [CHANNELS];
  logic [TICK_W-1:0] ticks;

  timer_result_t step_results [$];
  timer_result_t pending_results [$];

  int  fail_count = 0;
  int  op_count [4] = '{0, 0, 0, 0};
  int  deliveries_seen = 0;
  int  widest_service = 0;
  int  ready_hold = 0;
  bit  calm = 1'b0;

  multi_channel_oneshot_timer_bank_top #(
    .CHANNELS(CHANNELS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always #5 clk = ~clk;

  // Gap before the next transaction on either side; calm stretches run flat out
  function automatic int pick_gap();
    return calm ? 0 : int'($urandom_range(0, 14));
  endfunction

  // Advance the shadow bank by one item and collect the results it causes
  function automatic void timer_bank_step(input logic [OP_W-1:0] op,
                                          input logic [CH_W-1:0] ch,
                                          input logic [LOAD_W-1:0] load,
                                          input logic [TAG_W-1:0] tag);
    timer_result_t r;
    logic          any_hit;
    step_results.delete();
    case (op)
      OP_TICK: begin
        any_hit = 1'b0;
        ticks = ticks + 1'b1;
        for (int i = 0; i < CHANNELS; i++) begin
          if (is_armed[i] && !is_expired[i]) begin
            if (count_left[i] != '0) count_left[i] = count_left[i] - 1'b1;
            if (count_left[i] == '0) begin
              is_expired[i] = 1'b1;
              any_hit = 1'b1;
            end
          end
        end
        r = '{ticks, any_hit, 1'b0, 3'd0, 8'd0, 1'b1};
        step_results.push_back(r);
      end
      OP_ARM: begin
        if (int'(ch) < CHANNELS) begin
          cb_tag[ch] = tag;
          count_left[ch] = load;
          is_expired[ch] = 1'b0;
          is_armed[ch] = 1'b1;
        end
        r = '{ticks, 1'b0, 1'b0, 3'd0, 8'd0, 1'b1};
        step_results.push_back(r);
      end
      OP_DEARM: begin
        if (int'(ch) < CHANNELS) is_armed[ch] = 1'b0;
        r = '{ticks, 1'b0, 1'b0, 3'd0, 8'd0, 1'b1};
        step_results.push_back(r);
      end
      OP_SERVICE: begin
        // deliver pending channels in ascending order, disarming each
        for (int i = 0; i < CHANNELS; i++) begin
          if (is_armed[i] && is_expired[i]) begin
            is_armed[i] = 1'b0;
            is_expired[i] = 1'b0;
            r = '{ticks, 1'b0, 1'b1, CH_W'(i), cb_tag[i], 1'b0};
            step_results.push_back(r);
          end
        end
        if (step_results.size() == 0) begin
          r = '{ticks, 1'b0, 1'b0, 3'd0, 8'd0, 1'b1};
          step_results.push_back(r);
        end else begin
          step_results[$].fin = 1'b1;
        end
      end
    endcase
  endfunction

  // Drive one input transaction, then record what it should produce
  task automatic send_cmd(input cmd_row_t row);
    int gap;
    timer_result_t typed_res;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, row.tag, row.load, row.ch, row.op};
    do @(posedge clk); while (!s_axis_tready);
    timer_bank_step(row.op, row.ch, row.load, row.tag);
    if (row.typed) begin
      typed_res = '{row.tc, row.any, 1'b0, 3'd0, 8'd0, 1'b1};
      pending_results.push_back(typed_res);
    end else begin
      foreach (step_results[k]) pending_results.push_back(step_results[k]);
    end
    op_count[row.op]++;
    if (row.op == OP_SERVICE && step_results[0].delivered &&
        step_results.size() > widest_service)
      widest_service = step_results.size();
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  // Result side: random stalls, compare each transaction with the oldest expectation
  always @(posedge clk) begin
    timer_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: tdata %h last %b", m_axis_tdata, m_axis_tlast);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("tick_count", want.tick_count, m_axis_tdata[31:0]);
        check_field("tick_expired", 32'(want.tick_expired), 32'(m_axis_tdata[32]));
        check_field("delivered", 32'(want.delivered), 32'(m_axis_tdata[33]));
        check_field("expired_channel", 32'(want.channel), 32'(m_axis_tdata[36:34]));
        check_field("tag_out", 32'(want.tag), 32'(m_axis_tdata[44:37]));
        check_field("last", 32'(want.fin), 32'(m_axis_tlast));
      end
      if (m_axis_tdata[33]) deliveries_seen++;
      ready_hold = pick_gap();
    end else if (ready_hold > 0) begin
      ready_hold--;
    end
    m_axis_tready <= (ready_hold == 0);
  end

  // Stimulus
  initial begin
    cmd_row_t row;
    int       sent;
    int       pick;
    for (int i = 0; i < CHANNELS; i++) begin
      count_left[i] = '0;
      is_armed[i]   = 1'b0;
      is_expired[i] = 1'b0;
      cb_tag[i]     = '0;
    end
    ticks = '0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i]) send_cmd(DIRECTED[i]);

    // Random part: mostly single items, sometimes a full arm-tick-service burst
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 15) == 0) calm = !calm;
      row = '0;
      if ($urandom_range(0, 99) < 8) begin
        for (int c = 0; c < CHANNELS; c++) begin
          row.op   = OP_ARM;
          row.ch   = CH_W'(c);
          row.load = LOAD_W'($urandom_range(0, 2));
          row.tag  = TAG_W'($urandom_range(0, 255));
          send_cmd(row);
        end
        row = '0;
        row.op = OP_TICK;
        repeat (3) send_cmd(row);
        row.op = OP_SERVICE;
        send_cmd(row);
        sent += CHANNELS + 4;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 40)      row.op = OP_TICK;
        else if (pick < 72) row.op = OP_ARM;
        else if (pick < 80) row.op = OP_DEARM;
        else                row.op = OP_SERVICE;
        row.ch  = CH_W'($urandom_range(0, 7));
        row.tag = TAG_W'($urandom_range(0, 255));
        if ($urandom_range(0, 4) == 0) row.load = LOAD_W'($urandom_range(0, 65535));
        else                           row.load = LOAD_W'($urandom_range(0, 4));
        send_cmd(row);
        sent++;
      end
    end
    s_axis_tvalid <= 1'b0;

    // Drain, then leave room for any stray result
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Covered %0d ticks, %0d arms, %0d dearms, %0d services.",
             op_count[OP_TICK], op_count[OP_ARM], op_count[OP_DEARM], op_count[OP_SERVICE]);
    $display("%0d expirations delivered, at most %0d in one service.",
             deliveries_seen, widest_service);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
